// File: hdl/mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg - shared types and constants of the multi-slot countdown timer
// Slot mode codes, request kinds, register indexes and the packed layout of
// the input and result items.
// ----------------------------------------------------------------------------
package mct_pkg;

  // Number of countdown slots (1 to 8)
  localparam int SLOTS  = 3;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int MIN_W   = 7;
  localparam int REM_W   = 23;
  localparam int TAP_W   = 9;
  localparam int TGT_W   = 3;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 9;
  localparam int CFG_I_W = 1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // Milliseconds per minute
  localparam logic [REM_W-1:0] MS_PER_MIN = REM_W'(60000);

  // Register reset values
  localparam logic [TAP_W-1:0] TAP_SPLIT_RST   = TAP_W'(160);
  localparam logic [MIN_W-1:0] MAX_MINUTES_RST = MIN_W'(99);

  typedef enum logic [1:0] {
    MODE_SETTING = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_DONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_TAP    = 2'd1,
    REQ_LONG   = 2'd2,
    REQ_SWITCH = 2'd3
  } req_e;

  typedef enum logic [CFG_I_W-1:0] {
    CFG_TAP_SPLIT   = 1'b0,
    CFG_MAX_MINUTES = 1'b1
  } cfg_e;

  // Accepted input item
  typedef struct packed {
    req_e             req;
    logic [TAP_W-1:0] tap_x;
    logic [TGT_W-1:0] target_slot;
  } in_t;

  // Result item; last member sits in the lowest bits
  typedef struct packed {
    logic             any_active;
    logic             any_running;
    logic [IDX_W-1:0] alarm_slot;
    logic             alarm_active;
    logic [MIN_W-1:0] focused_minutes;
    logic [REM_W-1:0] focused_remaining_ms;
    mode_e            focused_state;
    logic [IDX_W-1:0] focused_slot;
  } out_t;

  // Set time of a slot after reset: 5 minutes per slot position
  function automatic logic [MIN_W-1:0] init_minutes(input int idx);
    init_minutes = MIN_W'(5 * (idx + 1));
  endfunction

  function automatic logic [REM_W-1:0] init_remaining(input int idx);
    init_remaining = REM_W'(5 * (idx + 1) * 60000);
  endfunction

endpackage

// File: hdl/multi_slot_countdown_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer - several countdown slots driven by events
// Ticks count running slots down; taps and long presses move slots between
// setting, running, paused and done; focus switches move the focus. One result per event.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transfer: tuser holds the event kind, tdata
//   the tap position and the focus target. m_axis returns one result per
//   event: the focused slot's mode, remaining time and set time plus the
//   alarm and activity summary over all slots, all as they stand after it.
//   cfg writes tap_split (index 0) and max_minutes (index 1); it is always
//   ready and must only be used while no event is in flight.
//   An event passes from the input register through the slot update logic
//   into the result register. Throughput is one event per cycle while the
//   receiver accepts results; the slot update for all slots plus one
//   minutes-to-milliseconds multiply sits between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more event, after which s_axis_tready drops.
//   Reset puts every slot in setting with 5, 10, 15 ... minutes, focus on
//   slot 0 and the registers at their defaults; no result is pending.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer
  import mct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Event stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [8:0] tap_x, [11:9] target_slot
  input  logic [1:0]            s_axis_tuser,  // [1:0] req_type
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [2:0] focused_slot,
                                               // [4:3] focused_state,
                                               // [27:5] focused_remaining_ms,
                                               // [34:28] focused_minutes,
                                               // [35] alarm_active,
                                               // [38:36] alarm_slot,
                                               // [39] any_running,
                                               // [40] any_active
  // Register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_I_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  // Configuration registers
  logic [TAP_W-1:0] tap_split_q;
  logic [MIN_W-1:0] max_minutes_q;

  // Slot state
  mode_e [SLOTS-1:0]             mode_q, mode_d;
  logic  [SLOTS-1:0][MIN_W-1:0]  minutes_q, minutes_d;
  logic  [SLOTS-1:0][REM_W-1:0]  rem_q, rem_d;
  logic  [SLOT_W-1:0]            focus_q, focus_d;

  // Pipeline registers
  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q, out_d;

  logic advance;

  // Event decode
  logic [SLOTS-1:0]  done_vec;
  logic              had_done;
  logic [SLOT_W-1:0] first_done;
  logic [SLOT_W-1:0] tap_slot;
  logic [MIN_W:0]    tap_min;
  logic [MIN_W:0]    top_min;
  logic [MIN_W-1:0]  new_min;
  logic [MIN_W-1:0]  mul_min;
  logic [REM_W-1:0]  set_ms;

  // Result summary
  logic              sum_run;
  logic              sum_act;
  logic              sum_alarm;
  logic [SLOT_W-1:0] sum_alarm_idx;

  // Handshakes
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_split_q   <= TAP_SPLIT_RST;
      max_minutes_q <= MAX_MINUTES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TAP_SPLIT:   tap_split_q   <= cfg_data_i;
        CFG_MAX_MINUTES: max_minutes_q <= cfg_data_i[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture an event on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.req         <= req_e'(s_axis_tuser);
      in_q.tap_x       <= s_axis_tdata[TAP_W-1:0];
      in_q.target_slot <= s_axis_tdata[TAP_W+TGT_W-1:TAP_W];
    end
  end

  // Find the lowest done slot before the event
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      done_vec[i] = (mode_q[i] == MODE_DONE);
    end
    had_done   = |done_vec;
    first_done = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (done_vec[i]) begin
        first_done = SLOT_W'(i);
      end
    end
    tap_slot = had_done ? first_done : focus_q;
  end

  // Adjust minutes for a tap in setting, clamped to 1..top
  always_comb begin
    top_min = (max_minutes_q == '0) ? (MIN_W+1)'(1) : {1'b0, max_minutes_q};
    if ({1'b0, in_q.tap_x} < {1'b0, tap_split_q}) begin
      tap_min = (minutes_q[tap_slot] > MIN_W'(1))
              ? {1'b0, minutes_q[tap_slot]} - (MIN_W+1)'(1)
              : (MIN_W+1)'(1);
    end else begin
      tap_min = {1'b0, minutes_q[tap_slot]} + (MIN_W+1)'(1);
    end
    if (tap_min > top_min) begin
      tap_min = top_min;
    end
    if (tap_min == '0) begin
      tap_min = (MIN_W+1)'(1);
    end
    new_min = tap_min[MIN_W-1:0];
  end

  // Pick the minutes that set a slot's remaining time
  always_comb begin
    case (in_q.req)
      REQ_TAP: begin
        mul_min = (mode_q[tap_slot] == MODE_SETTING) ? new_min : minutes_q[tap_slot];
      end
      default: mul_min = minutes_q[focus_q];
    endcase
  end

  assign set_ms = REM_W'(mul_min) * MS_PER_MIN;

  // Next slot state
  always_comb begin
    mode_d    = mode_q;
    minutes_d = minutes_q;
    rem_d     = rem_q;
    focus_d   = focus_q;
    case (in_q.req)
      REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (mode_q[i] == MODE_RUNNING) begin
            if (rem_q[i] != '0) begin
              rem_d[i] = rem_q[i] - REM_W'(1);
            end
            if (!had_done && rem_d[i] == '0) begin
              mode_d[i] = MODE_DONE;
            end
          end
        end
      end
      REQ_TAP: begin
        case (mode_q[tap_slot])
          MODE_SETTING: begin
            minutes_d[tap_slot] = new_min;
            rem_d[tap_slot]     = set_ms;
          end
          MODE_RUNNING: mode_d[tap_slot] = MODE_PAUSED;
          MODE_PAUSED:  mode_d[tap_slot] = MODE_RUNNING;
          default: begin
            mode_d[tap_slot] = MODE_SETTING;
            rem_d[tap_slot]  = set_ms;
          end
        endcase
      end
      REQ_LONG: begin
        if (mode_q[focus_q] == MODE_SETTING) begin
          mode_d[focus_q] = MODE_RUNNING;
        end else begin
          mode_d[focus_q] = MODE_SETTING;
          rem_d[focus_q]  = set_ms;
        end
      end
      default: begin
        if ({1'b0, in_q.target_slot} < (TGT_W+1)'(SLOTS)) begin
          focus_d = in_q.target_slot[SLOT_W-1:0];
        end
      end
    endcase
  end

  // Summarize the slots after the event
  always_comb begin
    sum_run       = 1'b0;
    sum_act       = 1'b0;
    sum_alarm     = 1'b0;
    sum_alarm_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mode_d[i] == MODE_RUNNING) begin
        sum_run = 1'b1;
        sum_act = 1'b1;
      end
      if (mode_d[i] == MODE_PAUSED) begin
        sum_act = 1'b1;
      end
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mode_d[i] == MODE_DONE) begin
        sum_alarm     = 1'b1;
        sum_alarm_idx = SLOT_W'(i);
      end
    end
    out_d.focused_slot         = IDX_W'(focus_d);
    out_d.focused_state        = mode_d[focus_d];
    out_d.focused_remaining_ms = rem_d[focus_d];
    out_d.focused_minutes      = minutes_d[focus_d];
    out_d.alarm_active         = sum_alarm;
    out_d.alarm_slot           = IDX_W'(sum_alarm_idx);
    out_d.any_running          = sum_run;
    out_d.any_active           = sum_act;
  end

  // Commit slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        mode_q[i]    <= MODE_SETTING;
        minutes_q[i] <= init_minutes(i);
        rem_q[i]     <= init_remaining(i);
      end
      focus_q <= '0;
    end else if (advance) begin
      mode_q    <= mode_d;
      minutes_q <= minutes_d;
      rem_q     <= rem_d;
      focus_q   <= focus_d;
    end
  end

  // Result register: load on advance, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(out_t))'(0), out_q};

  // Checks
  a_focus_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, focus_q} < (SLOT_W+1)'(SLOTS))
    else $error("focus index out of range");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.focused_slot == IDX_W'(focus_q)) &&
                    (out_q.focused_state == mode_q[focus_q]) &&
                    (out_q.focused_minutes == minutes_q[focus_q]))
    else $error("pending result differs from slot state");

  a_minutes_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.focused_minutes != '0)
    else $error("slot set time reached zero");

  a_tick_keeps_minutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.req == REQ_TICK) |=> $stable(minutes_q) && $stable(focus_q))
    else $error("tick changed set time or focus");

  a_alarm_slot_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.alarm_active) |->
      mode_q[out_q.alarm_slot[SLOT_W-1:0]] == MODE_DONE)
    else $error("alarm slot not in done mode");

endmodule
